[rtl/hbpm_pkg.sv]
package hbpm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_BLACK0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAINS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_FRAME = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PIX_CEIL  = 3'd6;

    localparam logic [47:0] WHITE_RST     = 48'hFFFF_FFFF_FFFF;
    localparam logic [59:0] GAINS_RST     = 60'h40_0004_0000_4000;
    localparam logic [1:0]  REF_FRAME_RST = 2'd1;
    localparam logic [15:0] PIX_CEIL_RST  = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  cfa_phase;
        logic [15:0] sample_0;
        logic [15:0] sample_1;
        logic [15:0] sample_2;
        logic [2:0]  in_bounds;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] merged_pixel;
        logic        used_fallback;
    } out_beat_t;

endpackage

[rtl/hbpm_div.sv]
// Pipelined restoring divider: one quotient bit per stage, MSB first.
// Stage i loads when en[i] is high.
module hbpm_div #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int Q_W    = 8,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic [Q_W-1:0]    en,
    input  logic [NUM_W-1:0]  num_in,
    input  logic [DEN_W-1:0]  den_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic [Q_W-1:0]    quo_out,
    output logic [SIDE_W-1:0] side_out
);

    localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [W-1:0]      rem_reg  [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [Q_W-1:0]    quo_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        localparam int B = Q_W - 1 - i;
        logic [W-1:0]      rem_in;
        logic [DEN_W-1:0]  den_i;
        logic [Q_W-1:0]    quo_i;
        logic [SIDE_W-1:0] side_i;
        logic [W-1:0]      trial;
        logic              fits;

        if (i == 0) begin : g_first
            assign rem_in = W'(num_in);
            assign den_i  = den_in;
            assign quo_i  = '0;
            assign side_i = side_in;
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign den_i  = den_reg[i-1];
            assign quo_i  = quo_reg[i-1];
            assign side_i = side_reg[i-1];
        end

        assign trial = W'(den_i) << B;
        assign fits  = rem_in >= trial;

        always_ff @(posedge aclk) begin
            if (en[i]) begin
                den_reg[i]  <= den_i;
                side_reg[i] <= side_i;
                quo_reg[i]  <= fits ? (quo_i | (Q_W'(1) << B)) : quo_i;
            end
        end

        if (i < Q_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en[i]) begin
                    rem_reg[i] <= fits ? rem_in - trial : rem_in;
                end
            end
        end
    end

    assign quo_out  = quo_reg[Q_W-1];
    assign side_out = side_reg[Q_W-1];

endmodule

[rtl/hdr_bracket_pixel_merge_core.sv]
// Throughput: one pixel per cycle unless stalled; the index divider and the mean divider each resolve
// one quotient bit per pipeline stage, so every stage takes a new beat each cycle.
// Stalls collapse bubbles stage by stage; input stalls only when every stage holds a beat.
// Reset (aresetn low, synchronous) empties the pipeline and loads default register values;
// the exposedness weight table is a constant built at elaboration.
module hdr_bracket_pixel_merge_core #(
    parameter int FRAMES           = 3,
    parameter int WEIGHT_LUT_DEPTH = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  hbpm_pkg::in_beat_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output hbpm_pkg::out_beat_t              m_data,
    input  logic                             cfg_wr_en,
    input  logic [hbpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hbpm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int IDX_W     = $clog2(WEIGHT_LUT_DEPTH);
    localparam int LUT_MAX   = WEIGHT_LUT_DEPTH - 1;
    localparam int IDX_NUM_W = IDX_W + 20;
    localparam int OUT_Q_W   = 16;

    localparam int ST_A    = 0;
    localparam int ST_B    = 1;
    localparam int ST_DV1  = 2;
    localparam int ST_LUT  = ST_DV1 + IDX_W;
    localparam int ST_MUL1 = ST_LUT + 1;
    localparam int ST_MUL2 = ST_MUL1 + 1;
    localparam int ST_SUM  = ST_MUL2 + 1;
    localparam int ST_OVF  = ST_SUM + 1;
    localparam int ST_DV2  = ST_OVF + 1;
    localparam int ST_OUT  = ST_DV2 + OUT_Q_W;
    localparam int NSTAGE  = ST_OUT + 1;

    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned Y_DIV   = 64'd512 * LUT_MAX * LUT_MAX;

    typedef logic [15:0] lut_t [WEIGHT_LUT_DEPTH];

    function automatic logic [15:0] gauss_weight(input int k);
        longint            s;
        longint unsigned   s2;
        longint unsigned   y;
        longint unsigned   term;
        longint unsigned   e;
        longint unsigned   w;
        longint            sum;
        s    = 3 * longint'(k) - 2 * longint'(LUT_MAX);
        s2   = longint'(s * s);
        y    = ((64'd25 * s2) << 30) / Y_DIV;
        term = Q30_ONE;
        sum  = longint'(Q30_ONE);
        for (int n = 1; n <= 8; n++) begin
            term = (term * y) >> 30;
            case (n)
                2:       term = term / 2;
                3:       term = term / 3;
                4:       term = term / 4;
                5:       term = term / 5;
                6:       term = term / 6;
                7:       term = term / 7;
                8:       term = term / 8;
                default: term = term;
            endcase
            if (n[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        e = longint'(sum);
        for (int i = 0; i < 6; i++) begin
            e = (e * e + (Q30_ONE >> 1)) >> 30;
        end
        w = ((e + 64'd8192) >> 14) + 64'd66;
        if (w > 64'd65535) begin
            w = 64'd65535;
        end
        return 16'(w);
    endfunction

    function automatic lut_t build_lut();
        lut_t tbl;
        for (int k = 0; k < WEIGHT_LUT_DEPTH; k++) begin
            tbl[k] = gauss_weight(k);
        end
        return tbl;
    endfunction

    localparam lut_t WEIGHT_LUT = build_lut();

    // ---------------- configuration ----------------
    logic [63:0] black_reg [3];
    logic [47:0] white_reg;
    logic [59:0] gains_reg;
    logic [1:0]  ref_frame_reg;
    logic [15:0] pix_ceil_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            black_reg[0]  <= '0;
            black_reg[1]  <= '0;
            black_reg[2]  <= '0;
            white_reg     <= hbpm_pkg::WHITE_RST;
            gains_reg     <= hbpm_pkg::GAINS_RST;
            ref_frame_reg <= hbpm_pkg::REF_FRAME_RST;
            pix_ceil_reg  <= hbpm_pkg::PIX_CEIL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hbpm_pkg::CFG_BLACK0:    black_reg[0]  <= cfg_wdata;
                hbpm_pkg::CFG_BLACK1:    black_reg[1]  <= cfg_wdata;
                hbpm_pkg::CFG_BLACK2:    black_reg[2]  <= cfg_wdata;
                hbpm_pkg::CFG_WHITE:     white_reg     <= cfg_wdata[47:0];
                hbpm_pkg::CFG_GAINS:     gains_reg     <= cfg_wdata[59:0];
                hbpm_pkg::CFG_REF_FRAME: ref_frame_reg <= cfg_wdata[1:0];
                hbpm_pkg::CFG_PIX_CEIL:  pix_ceil_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] v_in;
    logic [NSTAGE-1:0] en;

    // a stage loads when the output is ready or when it or any stage after it holds a bubble
    always_comb begin
        for (int i = 0; i < NSTAGE; i++) begin
            en[i] = m_ready || (((~v_reg) >> i) != '0);
        end
    end

    assign v_in = {v_reg[NSTAGE-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NSTAGE; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_in[i];
                end
            end
        end
    end

    assign s_ready = en[ST_A];
    assign m_valid = v_reg[ST_OUT];

    // ---------------- input side ----------------
    logic [15:0] raw_c [3];
    logic [1:0]  phase_c;
    logic [1:0]  ref_sel;
    logic [15:0] ref_blk;
    logic [15:0] fb_c;

    assign raw_c[0] = s_data.sample_0;
    assign raw_c[1] = s_data.sample_1;
    assign raw_c[2] = s_data.sample_2;
    assign phase_c  = s_data.cfa_phase;

    assign ref_sel = (ref_frame_reg >= 2'(FRAMES)) ? 2'(FRAMES - 1) : ref_frame_reg;
    assign ref_blk = black_reg[ref_sel][{phase_c, 4'd0} +: 16];
    assign fb_c    = (raw_c[ref_sel] > ref_blk) ? raw_c[ref_sel] - ref_blk : 16'd0;

    logic [15:0] fb_a_reg;
    logic [15:0] fb_b_reg;
    logic [15:0] fb_dv_reg [IDX_W];
    logic [15:0] fb_lut_reg;
    logic [15:0] fb_m1_reg;
    logic [15:0] fb_m2_reg;
    logic [15:0] fb_sum_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_A])    fb_a_reg   <= fb_c;
        if (en[ST_B])    fb_b_reg   <= fb_a_reg;
        if (en[ST_LUT])  fb_lut_reg <= fb_dv_reg[IDX_W-1];
        if (en[ST_MUL1]) fb_m1_reg  <= fb_lut_reg;
        if (en[ST_MUL2]) fb_m2_reg  <= fb_m1_reg;
        if (en[ST_SUM])  fb_sum_reg <= fb_m2_reg;
    end

    for (genvar i = 0; i < IDX_W; i++) begin : g_fb_dv
        if (i == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (en[ST_DV1]) fb_dv_reg[0] <= fb_b_reg;
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (en[ST_DV1+i]) fb_dv_reg[i] <= fb_dv_reg[i-1];
            end
        end
    end

    // ---------------- per-frame lanes ----------------
    logic [IDX_W-1:0] idx_q  [FRAMES];
    logic [51:0]      p2_reg [FRAMES];
    logic [15:0]      wk2_reg[FRAMES];

    for (genvar f = 0; f < FRAMES; f++) begin : g_frame
        logic [15:0]        blk;
        logic [15:0]        white;
        logic               clip;
        logic signed [17:0] n_c;
        logic [15:0]        d_c;
        logic signed [18:0] t_c;
        logic [15:0]        lin_c;

        logic [17:0]          t_a_reg;
        logic [15:0]          d_a_reg;
        logic [15:0]          lin_a_reg;
        logic                 keep_a_reg;
        logic [IDX_NUM_W-1:0] num_b_reg;
        logic [18:0]          d6_b_reg;
        logic [15:0]          lin_b_reg;
        logic                 keep_b_reg;
        logic [16:0]          side_dv;
        logic [15:0]          w_lut_reg;
        logic [15:0]          lin_lut_reg;
        logic                 keep_lut_reg;
        logic [31:0]          p1_reg;
        logic [15:0]          wk1_reg;

        assign blk   = black_reg[f][{phase_c, 4'd0} +: 16];
        assign white = white_reg[16*f +: 16];
        assign clip  = ({6'd0, raw_c[f]} * 22'd50) >= ({6'd0, white} * 22'd49);
        assign lin_c = (raw_c[f] > blk) ? raw_c[f] - blk : 16'd0;

        always_comb begin
            if (white > blk) begin
                n_c = $signed({2'b00, raw_c[f]}) - $signed({2'b00, blk});
                d_c = white - blk;
            end else begin
                n_c = '0;
                d_c = 16'd1;
            end
            if (n_c > $signed({2'b00, d_c})) begin
                n_c = $signed({2'b00, d_c});
            end
            t_c = $signed({n_c, 1'b0}) + $signed({3'b000, d_c});
        end

        always_ff @(posedge aclk) begin
            if (en[ST_A]) begin
                t_a_reg    <= t_c[18] ? 18'd0 : t_c[17:0];
                d_a_reg    <= d_c;
                lin_a_reg  <= lin_c;
                keep_a_reg <= s_data.in_bounds[f] && !clip;
            end
            if (en[ST_B]) begin
                num_b_reg  <= IDX_NUM_W'(t_a_reg) * IDX_NUM_W'(2 * LUT_MAX)
                            + IDX_NUM_W'(d_a_reg) * IDX_NUM_W'(3);
                d6_b_reg   <= 19'(d_a_reg) * 19'd6;
                lin_b_reg  <= lin_a_reg;
                keep_b_reg <= keep_a_reg;
            end
        end

        hbpm_div #(
            .NUM_W  (IDX_NUM_W),
            .DEN_W  (19),
            .Q_W    (IDX_W),
            .SIDE_W (17)
        ) u_idx_div (
            .aclk     (aclk),
            .en       (en[ST_DV1 +: IDX_W]),
            .num_in   (num_b_reg),
            .den_in   (d6_b_reg),
            .side_in  ({keep_b_reg, lin_b_reg}),
            .quo_out  (idx_q[f]),
            .side_out (side_dv)
        );

        always_ff @(posedge aclk) begin
            if (en[ST_LUT]) begin
                w_lut_reg    <= WEIGHT_LUT[idx_q[f]];
                lin_lut_reg  <= side_dv[15:0];
                keep_lut_reg <= side_dv[16];
            end
            if (en[ST_MUL1]) begin
                // drop clipped or out-of-bounds samples here
                p1_reg  <= keep_lut_reg ? 32'(w_lut_reg) * 32'(lin_lut_reg) : 32'd0;
                wk1_reg <= keep_lut_reg ? w_lut_reg : 16'd0;
            end
            if (en[ST_MUL2]) begin
                p2_reg[f]  <= 52'(p1_reg) * 52'(gains_reg[20*f +: 20]);
                wk2_reg[f] <= wk1_reg;
            end
        end
    end

    // ---------------- weighted mean ----------------
    logic [53:0] num_sum_c;
    logic [17:0] den_sum_c;
    logic [53:0] num_sum_reg;
    logic [17:0] den_sum_reg;

    always_comb begin
        num_sum_c = '0;
        den_sum_c = '0;
        for (int f = 0; f < FRAMES; f++) begin
            num_sum_c = num_sum_c + 54'(p2_reg[f]);
            den_sum_c = den_sum_c + 18'(wk2_reg[f]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_SUM]) begin
            num_sum_reg <= num_sum_c;
            den_sum_reg <= den_sum_c;
        end
    end

    logic [54:0] x_c;
    logic [31:0] dd_c;
    logic [54:0] x_reg;
    logic [31:0] dd_reg;
    logic        ovf_reg;
    logic        fbk_reg;
    logic [15:0] fb_ovf_reg;

    assign x_c  = 55'(num_sum_reg) + (55'(den_sum_reg) << 13);
    assign dd_c = {den_sum_reg, 14'd0};

    always_ff @(posedge aclk) begin
        if (en[ST_OVF]) begin
            x_reg      <= x_c;
            dd_reg     <= dd_c;
            // quotient would not fit 16 bits: saturate at the output
            ovf_reg    <= x_c >= {7'd0, dd_c, 16'd0};
            fbk_reg    <= den_sum_reg == '0;
            fb_ovf_reg <= fb_sum_reg;
        end
    end

    logic [OUT_Q_W-1:0] mean_q;
    logic [17:0]        side_out2;

    hbpm_div #(
        .NUM_W  (55),
        .DEN_W  (32),
        .Q_W    (OUT_Q_W),
        .SIDE_W (18)
    ) u_mean_div (
        .aclk     (aclk),
        .en       (en[ST_DV2 +: OUT_Q_W]),
        .num_in   (x_reg),
        .den_in   (dd_reg),
        .side_in  ({ovf_reg, fbk_reg, fb_ovf_reg}),
        .quo_out  (mean_q),
        .side_out (side_out2)
    );

    logic [15:0]         pix_c;
    hbpm_pkg::out_beat_t out_reg;

    always_comb begin
        if (side_out2[16]) begin
            pix_c = side_out2[15:0];
        end else if (side_out2[17]) begin
            pix_c = 16'hFFFF;
        end else begin
            pix_c = mean_q;
        end
        if (pix_c > pix_ceil_reg) begin
            pix_c = pix_ceil_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            out_reg.merged_pixel  <= pix_c;
            out_reg.used_fallback <= side_out2[16];
        end
    end

    assign m_data = out_reg;

    // ---------------- assertions ----------------
    a_out_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.merged_pixel <= pix_ceil_reg)
        else $error("merged pixel above output clamp");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[ST_LUT-1] |-> idx_q[0] <= IDX_W'(LUT_MAX))
        else $error("weight index beyond table");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v_reg[ST_A])
        else $error("accepted beat lost at pipeline entry");

endmodule
